/* hdl/stsi_pkg.sv */
package stsi_pkg;

  localparam int VAL_W = 32;
  localparam int ACT_W = 2;
  localparam int POS_W = 6;
  localparam int CNT_W = 7;

  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

  // Per-cycle commands broadcast from the controller to every cell.
  typedef struct packed {
    logic ins_en;
    logic cmp_en;
  } cell_ctl_t;

endpackage

/* hdl/stsi_cell.sv */
module stsi_cell import stsi_pkg::*; #(
  parameter int CW       = 7,
  parameter int CELL_IDX = 0
) (
  input  logic                    clk,
  input  cell_ctl_t               ctl,
  input  logic signed [VAL_W-1:0] key,
  input  logic [CW-1:0]           count,
  input  logic signed [VAL_W-1:0] prev_entry,
  input  logic                    prev_gt,
  output logic signed [VAL_W-1:0] entry,
  output logic                    gt,
  output logic                    lt_flag,
  output logic                    eq_flag
);

  logic signed [VAL_W-1:0] entry_r;
  logic                    lt_flag_r;
  logic                    eq_flag_r;
  logic                    filled;
  logic                    at_end;

  assign filled  = CW'(CELL_IDX) < count;
  assign at_end  = CW'(CELL_IDX) == count;
  assign gt      = filled && (entry_r > key);
  assign entry   = entry_r;
  assign lt_flag = lt_flag_r;
  assign eq_flag = eq_flag_r;

  // A cell takes its left neighbour's entry when that one moves up, or the
  // new value when it is the first greater entry or the first empty place.
  always_ff @(posedge clk) begin
    if (ctl.ins_en) begin
      if (prev_gt) begin
        entry_r <= prev_entry;
      end else if (gt || at_end) begin
        entry_r <= key;
      end
    end
    if (ctl.cmp_en) begin
      lt_flag_r <= entry_r < key;
      eq_flag_r <= entry_r == key;
    end
  end

endmodule

/* hdl/sorted_table_insert_search.sv */
// Sorted table with insert, binary search and clear. The table is a row of
// TABLE_DEPTH cells, each holding one signed 32-bit entry in ascending
// order, together with a fill count. A request is taken only while the
// controller is idle; its result goes to an output register, so the next
// request may be accepted while a result still waits to be taken. An insert
// captures the request, then every cell compares itself with the new value
// and each greater entry shifts up one place in step with its neighbour,
// then the result is loaded, waiting while the output register is stalled.
// A clear, or the unused action code, goes from capture straight to the
// load. A search captures the request, has all cells latch their compare
// flags together, then runs at most floor(log2(TABLE_DEPTH)) + 2 steps of
// binary search before the load; the steps are taken one a cycle by a
// single shared lower/upper bound unit. Entries hold no reset value; only
// filled entries are ever read. An insert into a full table changes
// nothing and reports table_full.
module sorted_table_insert_search import stsi_pkg::*; #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [ACT_W-1:0]        in_action,
  input  logic signed [VAL_W-1:0] in_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_found,
  output logic [POS_W-1:0]        out_position,
  output logic [CNT_W-1:0]        out_fill_count,
  output logic                    out_table_full
);

  // Index width and count width (the count must be able to hold the depth).
  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INSERT,
    S_CMP,
    S_SEARCH,
    S_DONE
  } state_t;

  state_t                  state_r;
  logic signed [VAL_W-1:0] key_r;
  logic [CW-1:0]           count_r;
  logic [CW-1:0]           lo_r;
  logic [CW-1:0]           hi_r;
  logic                    res_found_r;
  logic [IW-1:0]           res_pos_r;
  logic                    res_full_r;
  logic                    out_valid_r;
  logic                    out_found_r;
  logic [POS_W-1:0]        out_position_r;
  logic [CNT_W-1:0]        out_fill_count_r;
  logic                    out_table_full_r;

  logic [CW:0]             bound_sum;
  logic [CW-1:0]           mid;
  logic [IW-1:0]           mid_idx;
  logic                    cnt_full;
  logic [IW+POS_W-1:0]     pos_ext;
  logic [CW+CNT_W-1:0]     cnt_ext;
  cell_ctl_t               ctl;

  logic signed [VAL_W-1:0] entry_v [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]  gt_v;
  logic [TABLE_DEPTH-1:0]  lt_v;
  logic [TABLE_DEPTH-1:0]  eq_v;

  // Midpoint of the current search window; the upper bound is exclusive,
  // so while the window is open the midpoint always names a filled entry.
  assign bound_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid       = bound_sum[CW:1];
  assign mid_idx   = mid[IW-1:0];
  assign cnt_full  = count_r == CW'(TABLE_DEPTH);

  // Results wider than their fields are truncated, narrower ones extended.
  assign pos_ext = (IW + POS_W)'(res_pos_r);
  assign cnt_ext = (CW + CNT_W)'(count_r);

  always_comb begin
    ctl        = '0;
    ctl.ins_en = (state_r == S_INSERT) && !cnt_full;
    ctl.cmp_en = state_r == S_CMP;
  end

  // The row of cells. Cell 0 has no left neighbour, so it never shifts.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic signed [VAL_W-1:0] left_entry;
    logic                    left_gt;

    if (i == 0) begin : g_first
      assign left_entry = key_r;
      assign left_gt    = 1'b0;
    end else begin : g_rest
      assign left_entry = entry_v[i-1];
      assign left_gt    = gt_v[i-1];
    end

    stsi_cell #(
      .CW       (CW),
      .CELL_IDX (i)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .key        (key_r),
      .count      (count_r),
      .prev_entry (left_entry),
      .prev_gt    (left_gt),
      .entry      (entry_v[i]),
      .gt         (gt_v[i]),
      .lt_flag    (lt_v[i]),
      .eq_flag    (eq_v[i])
    );
  end

  assign in_stall       = state_r != S_IDLE;
  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_position   = out_position_r;
  assign out_fill_count = out_fill_count_r;
  assign out_table_full = out_table_full_r;

  // Controller: captures a request, runs it through the cells and the
  // search bounds, then hands the result to the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // In S_DONE the output register is managed by the load below.
      if (out_valid_r && !out_stall && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            key_r       <= in_value;
            res_found_r <= 1'b0;
            res_pos_r   <= '0;
            res_full_r  <= 1'b0;
            case (in_action)
              ACT_INSERT: state_r <= S_INSERT;
              ACT_SEARCH: state_r <= S_CMP;
              ACT_CLEAR: begin
                count_r <= '0;
                state_r <= S_DONE;
              end
              default:    state_r <= S_DONE;
            endcase
          end
        end
        S_INSERT: begin
          // The cells shift in this same cycle when there is room.
          if (cnt_full) begin
            res_full_r <= 1'b1;
          end else begin
            count_r <= count_r + CW'(1);
          end
          state_r <= S_DONE;
        end
        S_CMP: begin
          // Every cell latches its compare flags against the search key.
          lo_r    <= '0;
          hi_r    <= count_r;
          state_r <= S_SEARCH;
        end
        S_SEARCH: begin
          if (lo_r >= hi_r) begin
            state_r <= S_DONE;
          end else if (eq_v[mid_idx]) begin
            res_found_r <= 1'b1;
            res_pos_r   <= mid_idx;
            state_r     <= S_DONE;
          end else if (lt_v[mid_idx]) begin
            lo_r <= mid + CW'(1);
          end else begin
            hi_r <= mid;
          end
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r      <= 1'b1;
            out_found_r      <= res_found_r;
            out_position_r   <= pos_ext[POS_W-1:0];
            out_fill_count_r <= cnt_ext[CNT_W-1:0];
            out_table_full_r <= res_full_r;
            state_r          <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps

// Testbench for the sorted table block. A shadow copy of the table sits in
// the testbench and is updated on every accepted request; the outcome it
// predicts is queued and compared with the next result the block hands out.
// A short table of directed requests comes first, then random episodes of
// well-formed fill, search and clear sequences with some noise mixed in.
module tb;
  import stsi_pkg::*;

  localparam int TBL_DEPTH    = 64;
  localparam int RANDOM_ITEMS = 1100;
  // Cycles with no handshake on either side before the run is declared hung.
  // The limit lies far above the slowest search, the sender's longest pause
  // and the receiver's longest stall runs.
  localparam int HANG_LIMIT   = 4000;
  // Quiet time after the last result, well beyond the longest search.
  localparam int DRAIN_CYCLES = 24;
  localparam int MAX_REPORTS  = 10;

  // The fourth action code is not used by the block; it must act as a no-op.
  localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

  localparam logic signed [VAL_W-1:0] MIN_VAL = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] MAX_VAL = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
    logic [CNT_W-1:0] fill_count;
    logic             table_full;
  } outcome_t;

  localparam outcome_t NO_OUTCOME = '0;

  // One directed request. Where pinned is set, the outcome is written out by
  // hand; otherwise it is taken from the shadow table.
  typedef struct packed {
    logic [ACT_W-1:0]        act;
    logic signed [VAL_W-1:0] val;
    logic                    pinned;
    outcome_t                want;
  } dir_row_t;

  localparam int N_DIRECTED = 22;

  localparam dir_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    // Search of the empty table straight after reset.
    '{ACT_SEARCH, 32'sd0,   1'b1, '{1'b0, 6'd0, 7'd0, 1'b0}},
    // Extremes of the value range, inserted out of order.
    '{ACT_INSERT, MAX_VAL,  1'b1, '{1'b0, 6'd0, 7'd1, 1'b0}},
    '{ACT_INSERT, MIN_VAL,  1'b1, '{1'b0, 6'd0, 7'd2, 1'b0}},
    '{ACT_INSERT, 32'sd0,   1'b1, '{1'b0, 6'd0, 7'd3, 1'b0}},
    '{ACT_INSERT, -32'sd1,  1'b1, '{1'b0, 6'd0, 7'd4, 1'b0}},
    '{ACT_SEARCH, MIN_VAL,  1'b0, NO_OUTCOME},
    '{ACT_SEARCH, MAX_VAL,  1'b0, NO_OUTCOME},
    '{ACT_SEARCH, -32'sd1,  1'b0, NO_OUTCOME},
    '{ACT_SEARCH, 32'sd1,   1'b0, NO_OUTCOME},
    // Duplicates, then a search that may land on any of the equal entries.
    '{ACT_INSERT, 32'sd0,   1'b0, NO_OUTCOME},
    '{ACT_INSERT, 32'sd0,   1'b0, NO_OUTCOME},
    '{ACT_SEARCH, 32'sd0,   1'b0, NO_OUTCOME},
    // The spare action code only reports the fill count.
    '{ACT_SPARE,  32'sd5,   1'b1, '{1'b0, 6'd0, 7'd6, 1'b0}},
    '{ACT_INSERT, MAX_VAL,  1'b0, NO_OUTCOME},
    '{ACT_SEARCH, MAX_VAL,  1'b0, NO_OUTCOME},
    '{ACT_SEARCH, -32'sd2,  1'b0, NO_OUTCOME},
    // Clear, after which the old contents must be invisible.
    '{ACT_CLEAR,  32'sd0,   1'b1, '{1'b0, 6'd0, 7'd0, 1'b0}},
    '{ACT_SEARCH, -32'sd1,  1'b1, '{1'b0, 6'd0, 7'd0, 1'b0}},
    '{ACT_SPARE,  MIN_VAL,  1'b1, '{1'b0, 6'd0, 7'd0, 1'b0}},
    '{ACT_INSERT, 32'sd42,  1'b1, '{1'b0, 6'd0, 7'd1, 1'b0}},
    '{ACT_SEARCH, 32'sd42,  1'b1, '{1'b1, 6'd0, 7'd1, 1'b0}},
    '{ACT_CLEAR,  MAX_VAL,  1'b1, '{1'b0, 6'd0, 7'd0, 1'b0}}
  };

  logic                    clk            = 1'b0;
  logic                    rst_n          = 1'b0;
  logic                    in_valid       = 1'b0;
  logic                    in_stall;
  logic [ACT_W-1:0]        in_action      = ACT_INSERT;
  logic signed [VAL_W-1:0] in_value       = '0;
  logic                    out_valid;
  logic                    out_stall      = 1'b0;
  logic                    out_found;
  logic [POS_W-1:0]        out_position;
  logic [CNT_W-1:0]        out_fill_count;
  logic                    out_table_full;

  sorted_table_insert_search #(
    .TABLE_DEPTH(TBL_DEPTH)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_found     (out_found),
    .out_position  (out_position),
    .out_fill_count(out_fill_count),
    .out_table_full(out_table_full)
  );

  always #6 clk = ~clk;

  // Shadow copy of the table: entries below shadow_count are the live ones,
  // kept in ascending signed order exactly as the block should hold them.
  logic signed [VAL_W-1:0] shadow_entries [TBL_DEPTH];
  int                      shadow_count = 0;

  // Outcomes predicted for accepted requests, oldest first.
  outcome_t table_outcomes_q [$];

  int n_errors     = 0;
  int n_requests   = 0;
  int n_results    = 0;
  int n_inserts    = 0;
  int n_refused    = 0;
  int n_searches   = 0;
  int n_hits       = 0;
  int n_clears     = 0;
  int n_spare      = 0;
  int burst_left   = 0;
  int idle_cycles  = 0;

  // Applies one request to the shadow table and returns what the block
  // should report for it. Insert walks down from the top, moving every
  // strictly greater entry up one place, so equal values keep arrival order.
  // Search narrows a half-open window [lo, hi) and stops on the first equal
  // entry its path meets, which need not be the lowest equal one.
  function automatic outcome_t apply_to_shadow_table(input logic [ACT_W-1:0] act,
                                                     input logic signed [VAL_W-1:0] val);
    outcome_t o;
    int       k;
    int       lo;
    int       hi;
    int       mid;
    o = '0;
    case (act)
      ACT_INSERT: begin
        if (shadow_count >= TBL_DEPTH) begin
          o.table_full = 1'b1;
        end else begin
          k = shadow_count;
          while (k > 0 && shadow_entries[k-1] > val) begin
            shadow_entries[k] = shadow_entries[k-1];
            k--;
          end
          shadow_entries[k] = val;
          shadow_count++;
        end
      end
      ACT_SEARCH: begin
        lo = 0;
        hi = shadow_count;
        while (lo < hi && !o.found) begin
          mid = (lo + hi) >> 1;
          if (shadow_entries[mid] == val) begin
            o.found    = 1'b1;
            o.position = POS_W'(mid);
          end else if (val > shadow_entries[mid]) begin
            lo = mid + 1;
          end else begin
            hi = mid;
          end
        end
      end
      ACT_CLEAR: begin
        shadow_count = 0;
      end
      default: begin
      end
    endcase
    o.fill_count = CNT_W'(shadow_count);
    return o;
  endfunction

  // Values lean towards a narrow band around zero so that duplicates are
  // common, with the extremes and the full 32-bit range mixed in.
  function automatic logic signed [VAL_W-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) begin
      return VAL_W'($urandom);
    end else if (sel < 8) begin
      return VAL_W'($signed($urandom_range(0, 15)) - 8);
    end else if (sel == 8) begin
      return ($urandom_range(0, 1) != 0) ? MIN_VAL : MAX_VAL;
    end else begin
      return ($urandom_range(0, 1) != 0) ? -32'sd1 : 32'sd0;
    end
  endfunction

  // When the table holds entries, half of the searches look for a held value.
  function automatic logic signed [VAL_W-1:0] search_value();
    if (shadow_count > 0 && $urandom_range(0, 1) != 0) begin
      return shadow_entries[$urandom_range(0, shadow_count - 1)];
    end
    return pick_value();
  endfunction

  task automatic flag_error(input string msg);
    n_errors++;
    if (n_errors <= MAX_REPORTS) begin
      $display("%0t ERROR: %s", $realtime, msg);
    end
  endtask

  // Presents one request and holds it until the block takes it. The outcome
  // is predicted at the edge that accepts it, before the result can appear.
  // After the request the sender either carries on within its burst or falls
  // silent for a random number of cycles.
  task automatic send_request(input logic [ACT_W-1:0]        act,
                              input logic signed [VAL_W-1:0] val,
                              input logic                    pinned = 1'b0,
                              input outcome_t                pinned_want = NO_OUTCOME);
    outcome_t want;
    int       gap;
    in_valid  <= 1'b1;
    in_action <= act;
    in_value  <= val;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    want = apply_to_shadow_table(act, val);
    n_requests++;
    case (act)
      ACT_INSERT: begin
        n_inserts++;
        if (want.table_full) n_refused++;
      end
      ACT_SEARCH: begin
        n_searches++;
        if (want.found) n_hits++;
      end
      ACT_CLEAR: n_clears++;
      default:   n_spare++;
    endcase
    table_outcomes_q.push_back(pinned ? pinned_want : want);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Result side: checks every accepted result against the oldest prediction
  // and decides the stall for the next cycle. The stall pattern changes mode
  // every so often: no stall at all, light random stall, long on/off runs,
  // or heavy random stall. Values read here are those before the edge.
  int   stall_mode       = 0;
  int   stall_phase_left = 0;
  int   run_left         = 0;
  logic run_stalled      = 1'b0;

  always @(posedge clk) begin : result_side
    outcome_t got;
    outcome_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      got = '{out_found, out_position, out_fill_count, out_table_full};
      n_results++;
      if (table_outcomes_q.size() == 0) begin
        flag_error($sformatf("result with no request outstanding: found=%0b pos=%0d cnt=%0d full=%0b",
                             got.found, got.position, got.fill_count, got.table_full));
      end else begin
        want = table_outcomes_q.pop_front();
        if (got !== want) begin
          flag_error($sformatf({"result %0d: expected found=%0b pos=%0d cnt=%0d full=%0b, ",
                                "got found=%0b pos=%0d cnt=%0d full=%0b"},
                               n_results, want.found, want.position, want.fill_count,
                               want.table_full, got.found, got.position, got.fill_count,
                               got.table_full));
        end
      end
    end
    if (stall_phase_left == 0) begin
      stall_mode       = $urandom_range(0, 3);
      stall_phase_left = $urandom_range(16, 96);
    end else begin
      stall_phase_left--;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 9) < 3);
      2: begin
        if (run_left == 0) begin
          run_stalled = !run_stalled;
          run_left    = $urandom_range(1, 20);
        end else begin
          run_left--;
        end
        out_stall <= run_stalled;
      end
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Hang detection: cycles in which neither side completes a handshake.
  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0))
    begin
      idle_cycles <= 0;
    end else if (idle_cycles >= HANG_LIMIT) begin
      $display("Timeout: no request or result moved for %0d cycles", HANG_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int  kind;
    int  len;
    int  r;
    bit  first_episode;
    first_episode = 1'b1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests, in table order.
    for (int i = 0; i < N_DIRECTED; i++) begin
      send_request(DIRECTED_ROWS[i].act, DIRECTED_ROWS[i].val,
                   DIRECTED_ROWS[i].pinned, DIRECTED_ROWS[i].want);
    end

    // Random episodes. The first one always fills the table to capacity, so
    // that refused inserts into a full table are certain to be exercised.
    while (n_requests < N_DIRECTED + RANDOM_ITEMS) begin
      kind          = first_episode ? 0 : $urandom_range(0, 9);
      first_episode = 1'b0;
      if (kind <= 1) begin
        // Fill to the brim, push a few more in, then probe the full table.
        send_request(ACT_CLEAR, pick_value());
        while (shadow_count < TBL_DEPTH) begin
          if ($urandom_range(0, 3) == 0) send_request(ACT_SEARCH, search_value());
          else send_request(ACT_INSERT, pick_value());
        end
        repeat ($urandom_range(1, 4)) send_request(ACT_INSERT, pick_value());
        repeat ($urandom_range(4, 12)) send_request(ACT_SEARCH, search_value());
      end else if (kind <= 7) begin
        // Ordinary use: mostly a fresh table, inserts and searches mixed.
        if ($urandom_range(0, 4) != 0) send_request(ACT_CLEAR, pick_value());
        len = $urandom_range(5, 40);
        repeat (len) begin
          r = $urandom_range(0, 99);
          if (r < 55) send_request(ACT_INSERT, pick_value());
          else if (r < 95) send_request(ACT_SEARCH, search_value());
          else if (r < 98) send_request(ACT_SPARE, pick_value());
          else send_request(ACT_CLEAR, pick_value());
        end
      end else begin
        // Noise: any action code with any value.
        repeat (10) send_request(ACT_W'($urandom_range(0, 3)), VAL_W'($urandom));
      end
    end
    in_valid <= 1'b0;

    // Wait for every predicted result, then a little longer so that any
    // stray extra result would still be caught.
    while (table_outcomes_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (table_outcomes_q.size() != 0) begin
      flag_error($sformatf("%0d predicted results never arrived", table_outcomes_q.size()));
    end

    $display("Covered %0d requests: %0d inserts (%0d refused as full), %0d searches (%0d hits),",
             n_requests, n_inserts, n_refused, n_searches, n_hits);
    $display("  %0d clears, %0d spare codes; %0d results checked, %0d errors.",
             n_clears, n_spare, n_results, n_errors);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/stsi_pkg.sv
hdl/stsi_cell.sv
hdl/sorted_table_insert_search.sv
tb/sv/tb.sv
